// ----- hw/rtl/wli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wli_pkg: shared types and constants of the waypoint line interpolator
// Coordinate and step widths, register reset value, queue depth and the
// segment descriptor passed from the front end to the sample generator.
// ----------------------------------------------------------------------------
package wli_pkg;

  localparam int CoordW    = 32;            // signed Q16.16 coordinate
  localparam int StepW     = 16;            // unsigned Q0.16 step, fraction only
  localparam int FifoDepth = 2;             // segment queue entries

  localparam logic [StepW-1:0] StepReset = 16'd3277;  // 0.05 m

  // One segment to walk, already classified by major axis.
  typedef struct packed {
    logic              xmajor;   // x is the major axis
    logic              maj_neg;  // major delta is negative
    logic              min_neg;  // minor delta is negative
    logic [CoordW-1:0] maj0;     // start coordinate on the major axis
    logic [CoordW-1:0] min0;     // start coordinate on the minor axis
    logic [CoordW-1:0] amaj;     // |major delta|, never zero
    logic [CoordW-1:0] amin;     // |minor delta|, <= amaj
  } seg_t;

endpackage

// ----- hw/rtl/waypoint_line_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_line_interpolator: straight-line sampling between waypoints
// Walks from each waypoint to the next in sample_step increments along the
// major axis and emits the points in between.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries waypoints (x, y in tdata, list_start in tuser). The first
//   waypoint of a list produces nothing and sets the previous point to the
//   origin; each later waypoint produces up to MAX_RUN points on m_axis
//   (x, y in tdata), tlast on the last point of the run, tuser set on every
//   point of a run that was cut at MAX_RUN.
//   The cfg channel writes sample_step (0 acts as 1); write it only while
//   the block is idle. cfg_ready_o is always high.
//   Intake takes one waypoint per cycle while the two-entry segment queue
//   has room. Each segment then goes through setup (queue pop, multiply,
//   16-step slope divider) before its points are emitted, and the
//   generator pops the next segment only after the last point of the
//   current run has been emitted.
//   Reset clears the previous point, the list state, the queue and the
//   output register, and loads sample_step with 0.05 m. When the receiver
//   stalls, the output register holds its point, the generator waits and
//   intake keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module waypoint_line_interpolator import wli_pkg::*; #(
  parameter int MAX_RUN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [StepW-1:0]    cfg_data_i,     // sample_step
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*CoordW-1:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y
  input  logic [0:0]          s_axis_tuser,   // [0] list_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*CoordW-1:0] m_axis_tdata,   // [31:0] sample_x, [63:32] sample_y
  output logic                m_axis_tlast,   // last_of_run
  output logic [0:0]          m_axis_tuser    // [0] run_cut
);

  logic [StepW-1:0] sample_step_q;
  logic [StepW-1:0] step_eff;

  logic seg_push, seg_full, seg_pop, seg_valid;
  seg_t seg_in, seg_out;

  assign cfg_ready_o = 1'b1;
  assign step_eff    = (sample_step_q == '0) ? StepW'(1) : sample_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_step_q <= StepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sample_step_q <= cfg_data_i;
    end
  end

  wli_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .seg_full_i   (seg_full),
    .seg_push_o   (seg_push),
    .seg_o        (seg_in)
  );

  wli_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (seg_push),
    .data_i (seg_in),
    .full_o (seg_full),
    .pop_i  (seg_pop),
    .valid_o(seg_valid),
    .data_o (seg_out)
  );

  wli_back #(
    .MAX_RUN(MAX_RUN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step_eff),
    .seg_valid_i  (seg_valid),
    .seg_i        (seg_out),
    .seg_pop_o    (seg_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// ----- hw/rtl/wli_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wli_front: waypoint intake
// Tracks the previous point, handles list starts and turns each later
// waypoint into a segment descriptor with its major axis picked.
// ----------------------------------------------------------------------------
module wli_front import wli_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*CoordW-1:0] s_axis_tdata,   // point_x, point_y
  input  logic [0:0]          s_axis_tuser,   // list_start
  input  logic                seg_full_i,
  output logic                seg_push_o,
  output seg_t                seg_o
);

  logic [CoordW-1:0] prev_x_q, prev_x_d;
  logic [CoordW-1:0] prev_y_q, prev_y_d;
  logic              have_start_q, have_start_d;

  logic              accept;
  logic              new_list;
  logic [CoordW-1:0] px, py;
  logic [CoordW:0]   dx, dy;
  logic [CoordW-1:0] adx, ady;
  logic              xmajor;

  assign s_axis_tready = !seg_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign px            = s_axis_tdata[CoordW-1:0];
  assign py            = s_axis_tdata[2*CoordW-1:CoordW];
  assign new_list      = s_axis_tuser[0] || !have_start_q;

  // 33-bit deltas cannot overflow; magnitudes fit in 32 bits
  assign dx  = {px[CoordW-1], px} - {prev_x_q[CoordW-1], prev_x_q};
  assign dy  = {py[CoordW-1], py} - {prev_y_q[CoordW-1], prev_y_q};
  assign adx = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
  assign ady = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
  assign xmajor = adx >= ady;

  always_comb begin
    seg_o.xmajor  = xmajor;
    seg_o.maj_neg = xmajor ? dx[CoordW] : dy[CoordW];
    seg_o.min_neg = xmajor ? dy[CoordW] : dx[CoordW];
    seg_o.maj0    = xmajor ? prev_x_q : prev_y_q;
    seg_o.min0    = xmajor ? prev_y_q : prev_x_q;
    seg_o.amaj    = xmajor ? adx : ady;
    seg_o.amin    = xmajor ? ady : adx;
  end

  // same point: nothing to walk
  assign seg_push_o = accept && !new_list && (seg_o.amaj != '0);

  always_comb begin
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    have_start_d = have_start_q;
    if (accept) begin
      if (new_list) begin
        prev_x_d     = '0;
        prev_y_d     = '0;
        have_start_d = 1'b1;
      end else begin
        prev_x_d = px;
        prev_y_d = py;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      have_start_q <= 1'b0;
    end else begin
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      have_start_q <= have_start_d;
    end
  end

endmodule

// ----- hw/rtl/wli_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wli_fifo: segment queue
// Small register queue that decouples waypoint intake from sample output.
// ----------------------------------------------------------------------------
module wli_fifo import wli_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  seg_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output seg_t data_o
);

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FifoDepth);

  seg_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntFull;
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("segment queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("segment queue popped while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("segment queue count out of range");

endmodule

// ----- hw/rtl/wli_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wli_back: sample generator
// Per segment: one slope division (16 restoring steps), then one point per
// cycle while the output is free, from a running minor-axis quotient/remainder.
// ----------------------------------------------------------------------------
module wli_back import wli_pkg::*; #(
  parameter int MAX_RUN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [StepW-1:0]    step_i,       // never zero
  input  logic                seg_valid_i,
  input  seg_t                seg_i,
  output logic                seg_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*CoordW-1:0] m_axis_tdata,  // sample_x, sample_y
  output logic                m_axis_tlast,  // last_of_run
  output logic [0:0]          m_axis_tuser   // run_cut
);

  localparam int CntW    = $clog2(MAX_RUN + 1);
  localparam int AlongW  = StepW + CntW;
  localparam int ProdW   = CoordW + StepW;
  localparam int DivCntW = $clog2(StepW);
  localparam logic [CntW-1:0]    RunLast = CntW'(MAX_RUN);
  localparam logic [AlongW-1:0]  RunPlus = AlongW'(MAX_RUN + 1);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(StepW - 1);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_PREP, B_DIV, B_EMIT} state_e;

  state_e             state_q;
  seg_t               seg_q;
  logic [ProdW-1:0]   prod_q;
  logic [AlongW-1:0]  lim_q;
  logic [CoordW-1:0]  rem_q;
  logic [StepW-1:0]   dlo_q;
  logic [StepW-1:0]   quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [StepW-1:0]   qstep_q;
  logic [CoordW-1:0]  rstep_q;
  logic [AlongW-1:0]  along_q;
  logic [AlongW-1:0]  q_q;
  logic [CoordW-1:0]  r_q;
  logic [CntW-1:0]    n_q;
  logic               cut_q;
  logic               m_valid_q;
  logic [2*CoordW-1:0] m_data_q;
  logic               m_last_q;
  logic               m_cut_q;

  logic [ProdW-1:0]   prod_d;
  logic [AlongW-1:0]  lim_d;
  logic [CoordW:0]    rem_sh;
  logic               div_ge;
  logic [CoordW-1:0]  rem_nx;
  logic [StepW-1:0]   quo_nx;
  logic [CoordW-1:0]  along32;
  logic [AlongW-1:0]  along_nx;
  logic [CoordW-1:0]  maj_val, min_val, off;
  logic               rnd;
  logic [CoordW:0]    r_sum;
  logic               r_wrap;
  logic [CoordW-1:0]  r_nx;
  logic [AlongW-1:0]  q_nx;
  logic               is_last;
  logic               out_free;
  logic               emit;

  assign prod_d = ProdW'(seg_q.amin) * ProdW'(step_i);
  assign lim_d  = RunPlus * AlongW'(step_i);

  // restoring division of |dmin|*step by |dmaj|; quotient fits in StepW bits
  assign rem_sh = {rem_q, dlo_q[StepW-1]};
  assign div_ge = rem_sh >= {1'b0, seg_q.amaj};
  assign rem_nx = div_ge ? CoordW'(rem_sh - {1'b0, seg_q.amaj}) : rem_sh[CoordW-1:0];
  assign quo_nx = {quo_q[StepW-2:0], div_ge};

  assign along32  = CoordW'(along_q);
  assign along_nx = along_q + AlongW'(step_i);
  assign maj_val  = seg_q.maj_neg ? seg_q.maj0 - along32 : seg_q.maj0 + along32;

  // round half away from zero on the magnitude
  assign rnd     = {r_q, 1'b0} >= {1'b0, seg_q.amaj};
  assign off     = CoordW'(q_q) + CoordW'(rnd);
  assign min_val = seg_q.min_neg ? seg_q.min0 - off : seg_q.min0 + off;

  assign r_sum  = {1'b0, r_q} + {1'b0, rstep_q};
  assign r_wrap = r_sum >= {1'b0, seg_q.amaj};
  assign r_nx   = r_wrap ? CoordW'(r_sum - {1'b0, seg_q.amaj}) : r_sum[CoordW-1:0];
  assign q_nx   = q_q + AlongW'(qstep_q) + AlongW'(r_wrap);

  assign is_last  = (n_q == RunLast) || (CoordW'(along_nx) >= seg_q.amaj);
  assign out_free = !m_valid_q || m_axis_tready;
  assign emit     = (state_q == B_EMIT) && out_free;

  assign seg_pop_o     = (state_q == B_IDLE) && seg_valid_i;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_cut_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      seg_q     <= '0;
      prod_q    <= '0;
      lim_q     <= '0;
      rem_q     <= '0;
      dlo_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
      qstep_q   <= '0;
      rstep_q   <= '0;
      along_q   <= '0;
      q_q       <= '0;
      r_q       <= '0;
      n_q       <= '0;
      cut_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
      m_cut_q   <= 1'b0;
    end else begin
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (seg_valid_i) begin
            seg_q   <= seg_i;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          prod_q  <= prod_d;
          lim_q   <= lim_d;
          state_q <= B_PREP;
        end
        B_PREP: begin
          rem_q     <= prod_q[ProdW-1:StepW];
          dlo_q     <= prod_q[StepW-1:0];
          quo_q     <= '0;
          div_cnt_q <= '0;
          cut_q     <= CoordW'(lim_q) < seg_q.amaj;
          // first step already reaches the endpoint: empty run
          if (CoordW'(step_i) >= seg_q.amaj) begin
            state_q <= B_IDLE;
          end else begin
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          rem_q     <= rem_nx;
          dlo_q     <= {dlo_q[StepW-2:0], 1'b0};
          quo_q     <= quo_nx;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DivLast) begin
            qstep_q <= quo_nx;
            rstep_q <= rem_nx;
            q_q     <= AlongW'(quo_nx);
            r_q     <= rem_nx;
            along_q <= AlongW'(step_i);
            n_q     <= CntW'(1);
            state_q <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            m_data_q  <= seg_q.xmajor ? {min_val, maj_val} : {maj_val, min_val};
            m_last_q  <= is_last;
            m_cut_q   <= cut_q;
            along_q   <= along_nx;
            q_q       <= q_nx;
            r_q       <= r_nx;
            n_q       <= n_q + 1'b1;
            if (is_last) begin
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_along_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT) |-> (along32 < seg_q.amaj))
    else $error("sample position reached the segment end");

  a_resid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT) |-> (r_q < seg_q.amaj))
    else $error("minor-axis remainder out of range");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT) |-> (n_q != '0 && n_q <= RunLast))
    else $error("point index out of range");

  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> (state_q == B_IDLE))
    else $error("run did not end after its last point");

endmodule
